[src/tloa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tloa_pkg
// shared constants, codes and types for the local operator apply block
// ----------------------------------------------------------------------------
package tloa_pkg;

	localparam int MAX_BOND_RANK = 4;
	localparam int MAX_OP_RANK   = 4;
	localparam int MAX_MODE      = 4;

	localparam int ENV_DEPTH  = MAX_BOND_RANK * MAX_OP_RANK * MAX_BOND_RANK;
	localparam int CORE_DEPTH = MAX_OP_RANK * MAX_MODE * MAX_MODE * MAX_OP_RANK;
	localparam int VEC_DEPTH  = MAX_BOND_RANK * MAX_MODE * MAX_BOND_RANK;
	localparam int ST1_DEPTH  = MAX_BOND_RANK * MAX_OP_RANK * MAX_MODE * MAX_BOND_RANK;
	localparam int ST2_DEPTH  = MAX_BOND_RANK * MAX_BOND_RANK * MAX_MODE * MAX_OP_RANK;

	localparam int ENV_AW  = $clog2(ENV_DEPTH);
	localparam int CORE_AW = $clog2(CORE_DEPTH);
	localparam int VEC_AW  = $clog2(VEC_DEPTH);
	localparam int ST1_AW  = $clog2(ST1_DEPTH);
	localparam int ST2_AW  = $clog2(ST2_DEPTH);

	localparam int ACC_W = 80;

	localparam logic [2:0] ACT_LEFT    = 3'd0;
	localparam logic [2:0] ACT_CORE    = 3'd1;
	localparam logic [2:0] ACT_RIGHT   = 3'd2;
	localparam logic [2:0] ACT_VECTOR  = 3'd3;
	localparam logic [2:0] ACT_COMPUTE = 3'd4;

	localparam logic [2:0] REG_LEFT_RANK  = 3'd0;
	localparam logic [2:0] REG_LEFT_OP    = 3'd1;
	localparam logic [2:0] REG_MODE       = 3'd2;
	localparam logic [2:0] REG_RIGHT_OP   = 3'd3;
	localparam logic [2:0] REG_RIGHT_RANK = 3'd4;
	localparam logic [2:0] REG_REG        = 3'd5;

	// clamped sizes, 1..4
	typedef struct packed {
		logic [2:0] nl;
		logic [2:0] ns;
		logic [2:0] nm;
		logic [2:0] nS;
		logic [2:0] nL;
	} sizes_t;

	// sequencer to datapath control
	typedef struct packed {
		logic       mac;    // product valid this cycle
		logic       clr;    // first product of a sum
		logic       fin;    // last product of a sum
		logic [1:0] stage;  // 1..3
	} mac_ctl_t;

	function automatic logic [2:0] clampsz(input logic [2:0] v, input logic [2:0] mx);
		logic [2:0] r;
		r = v;
		if (v == 3'd0) r = 3'd1;
		else if (v > mx) r = mx;
		return r;
	endfunction

	// Q32.32 sum to Q16.16, round half up, saturate
	function automatic logic signed [31:0] finish(input logic signed [ACC_W-1:0] a);
		logic signed [ACC_W-1:0] r;
		logic signed [ACC_W-1:0] h;
		logic signed [31:0] o;
		r = a + ACC_W'(32768);
		h = r >>> 32;
		if (h >= ACC_W'(32768)) o = 32'sh7fffffff;
		else if (h < -ACC_W'(32768)) o = 32'sh80000000;
		else o = r[47:16];
		return o;
	endfunction

endpackage

[src/tt_local_operator_apply_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tt_local_operator_apply_top
// tensor-train local operator apply in q16.16 over six on-chip memories
// ----------------------------------------------------------------------------
// channel | signals                              | flow
// input   | start, busy, action, index, value    | start while busy low takes an item
// result  | valid, result_value, result_index, last | one-cycle strobe per result, no stall
// config  | psel penable pwrite paddr pwdata prdata pready | apb, zero wait
//
// a write item is taken without raising busy
// compute runs stage 1, 2, 3 on one multiplier: one product per cycle, and a
// drain state after each stage lets its last sum land before moving on;
// results leave from stage 3 as each sum finishes, in row-major order
// reset is asynchronous; memory contents are undefined until written
// the receiver cannot stall; results are strobed once
// ----------------------------------------------------------------------------
module tt_local_operator_apply_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         action,
	input  logic [7:0]         index,
	input  logic signed [31:0] value,
	output logic               valid,
	output logic signed [31:0] result_value,
	output logic [5:0]         result_index,
	output logic               last,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	// config registers
	logic [2:0] left_rank_q, left_op_q, mode_q, right_op_q, right_rank_q;
	logic signed [31:0] reg_q;
	logic cfg_wr;
	logic [2:0] cfg_sel;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_sel = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_rank_q <= 3'd1; left_op_q <= 3'd1; mode_q <= 3'd1;
			right_op_q <= 3'd1; right_rank_q <= 3'd1; reg_q <= '0;
		end else if (cfg_wr && paddr[1:0] == 2'b00) begin
			case (cfg_sel)
				tloa_pkg::REG_LEFT_RANK:  left_rank_q  <= pwdata[2:0];
				tloa_pkg::REG_LEFT_OP:    left_op_q    <= pwdata[2:0];
				tloa_pkg::REG_MODE:       mode_q       <= pwdata[2:0];
				tloa_pkg::REG_RIGHT_OP:   right_op_q   <= pwdata[2:0];
				tloa_pkg::REG_RIGHT_RANK: right_rank_q <= pwdata[2:0];
				tloa_pkg::REG_REG:        reg_q        <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_sel)
			tloa_pkg::REG_LEFT_RANK:  prdata = {29'd0, left_rank_q};
			tloa_pkg::REG_LEFT_OP:    prdata = {29'd0, left_op_q};
			tloa_pkg::REG_MODE:       prdata = {29'd0, mode_q};
			tloa_pkg::REG_RIGHT_OP:   prdata = {29'd0, right_op_q};
			tloa_pkg::REG_RIGHT_RANK: prdata = {29'd0, right_rank_q};
			tloa_pkg::REG_REG:        prdata = reg_q;
			default:                  prdata = '0;
		endcase
	end

	tloa_pkg::sizes_t sz;
	always_comb begin
		sz.nl = tloa_pkg::clampsz(left_rank_q, 3'(tloa_pkg::MAX_BOND_RANK));
		sz.ns = tloa_pkg::clampsz(left_op_q, 3'(tloa_pkg::MAX_OP_RANK));
		sz.nm = tloa_pkg::clampsz(mode_q, 3'(tloa_pkg::MAX_MODE));
		sz.nS = tloa_pkg::clampsz(right_op_q, 3'(tloa_pkg::MAX_OP_RANK));
		sz.nL = tloa_pkg::clampsz(right_rank_q, 3'(tloa_pkg::MAX_BOND_RANK));
	end

	// item accept and load writes
	logic take, go;
	assign take = start && !busy;
	assign go   = take && action == tloa_pkg::ACT_COMPUTE;

	wire wl = take && action == tloa_pkg::ACT_LEFT   && index < 8'(tloa_pkg::ENV_DEPTH);
	wire wc = take && action == tloa_pkg::ACT_CORE;
	wire wr = take && action == tloa_pkg::ACT_RIGHT  && index < 8'(tloa_pkg::ENV_DEPTH);
	wire wv = take && action == tloa_pkg::ACT_VECTOR && index < 8'(tloa_pkg::VEC_DEPTH);

	// sequencer
	tloa_pkg::mac_ctl_t ctl, ctl_s1;
	logic [tloa_pkg::ENV_AW-1:0]  left_ra, right_ra;
	logic [tloa_pkg::CORE_AW-1:0] core_ra;
	logic [tloa_pkg::VEC_AW-1:0]  vec_ra;
	logic [tloa_pkg::ST1_AW-1:0]  st1_ra;
	logic [tloa_pkg::ST2_AW-1:0]  st2_ra;
	logic [7:0] oidx;
	logic olast;

	tloa_seq u_seq (
		.clk, .arst_n, .go, .sz, .busy, .ctl,
		.left_ra, .core_ra, .right_ra, .vec_ra, .st1_ra, .st2_ra,
		.out_idx(oidx), .out_last(olast)
	);

	// result index travels with the sum through read, multiply, accumulate
	logic [5:0] idx_s1, idx_s2, idx_s3;
	logic last_s1, last_s2, last_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ctl_s1 <= '0;
		else ctl_s1 <= ctl;
	end
	always_ff @(posedge clk) begin
		idx_s1 <= oidx[5:0]; idx_s2 <= idx_s1; idx_s3 <= idx_s2;
		last_s1 <= olast; last_s2 <= last_s1; last_s3 <= last_s2;
	end

	// write-back address of stage 1/2 results
	logic [tloa_pkg::ST1_AW-1:0] wb_q, wb_base;
	logic done; logic [1:0] done_stage; logic signed [31:0] done_value;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) wb_q <= '0;
		else if (go) wb_q <= '0;
		else if (done && done_stage != 2'd3) wb_q <= (wb_q == wb_base) ? '0 : wb_q + 1'b1;
	end
	// last flat index of the stage in progress
	always_comb begin
		if (done_stage == 2'd1)
			wb_base = tloa_pkg::ST1_AW'(sz.nl * sz.ns * sz.nm * sz.nL - 1);
		else
			wb_base = tloa_pkg::ST1_AW'(sz.nl * sz.nL * sz.nm * sz.nS - 1);
	end

	// memories
	logic [31:0] left_rd, core_rd, right_rd, vec_rd, st1_rd, st2_rd;
	tloa_ram #(.WIDTH(32), .DEPTH(tloa_pkg::ENV_DEPTH)) u_left (
		.clk, .we(wl), .waddr(index[tloa_pkg::ENV_AW-1:0]), .wdata(value),
		.raddr(left_ra), .rdata(left_rd));
	tloa_ram #(.WIDTH(32), .DEPTH(tloa_pkg::CORE_DEPTH)) u_core (
		.clk, .we(wc), .waddr(index[tloa_pkg::CORE_AW-1:0]), .wdata(value),
		.raddr(core_ra), .rdata(core_rd));
	tloa_ram #(.WIDTH(32), .DEPTH(tloa_pkg::ENV_DEPTH)) u_right (
		.clk, .we(wr), .waddr(index[tloa_pkg::ENV_AW-1:0]), .wdata(value),
		.raddr(right_ra), .rdata(right_rd));
	tloa_ram #(.WIDTH(32), .DEPTH(tloa_pkg::VEC_DEPTH)) u_vec (
		.clk, .we(wv), .waddr(index[tloa_pkg::VEC_AW-1:0]), .wdata(value),
		.raddr(vec_ra), .rdata(vec_rd));
	tloa_ram #(.WIDTH(32), .DEPTH(tloa_pkg::ST1_DEPTH)) u_st1 (
		.clk, .we(done && done_stage == 2'd1), .waddr(wb_q), .wdata(done_value),
		.raddr(st1_ra), .rdata(st1_rd));
	tloa_ram #(.WIDTH(32), .DEPTH(tloa_pkg::ST2_DEPTH)) u_st2 (
		.clk, .we(done && done_stage == 2'd2), .waddr(wb_q), .wdata(done_value),
		.raddr(st2_ra), .rdata(st2_rd));

	// operand select per stage
	logic signed [31:0] x_s1, y_s1;
	always_comb begin
		case (ctl_s1.stage)
			2'd1: begin x_s1 = left_rd; y_s1 = vec_rd; end
			2'd2: begin x_s1 = st1_rd;  y_s1 = core_rd; end
			2'd3: begin x_s1 = st2_rd;  y_s1 = right_rd; end
			default: begin x_s1 = '0; y_s1 = '0; end
		endcase
	end

	tloa_mac u_mac (
		.clk, .arst_n, .ctl_s1, .x_s1, .y_s1,
		.rx_s1(reg_q), .ry_s1(vec_rd),
		.done, .done_stage, .done_value
	);

	assign valid        = done && done_stage == 2'd3;
	assign result_value = done_value;
	assign result_index = idx_s3;
	assign last         = last_s3;
endmodule

[src/tloa_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tloa_ram
// generic single-port-write, single-read ram with registered read
// ----------------------------------------------------------------------------
module tloa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

[src/tloa_seq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tloa_seq
// loop sequencer: walks the three contraction stages and makes addresses
// ----------------------------------------------------------------------------
module tloa_seq (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        go,
	input  tloa_pkg::sizes_t            sz,
	output logic                        busy,
	output tloa_pkg::mac_ctl_t          ctl,
	output logic [tloa_pkg::ENV_AW-1:0]  left_ra,
	output logic [tloa_pkg::CORE_AW-1:0] core_ra,
	output logic [tloa_pkg::ENV_AW-1:0]  right_ra,
	output logic [tloa_pkg::VEC_AW-1:0]  vec_ra,
	output logic [tloa_pkg::ST1_AW-1:0]  st1_ra,
	output logic [tloa_pkg::ST2_AW-1:0]  st2_ra,
	output logic [7:0]                  out_idx,
	output logic                        out_last
);
	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_RUN  = 4'b0010,
		S_DRAIN = 4'b0100,
		S_REG  = 4'b1000
	} state_t;

	state_t state_q;
	logic [1:0] stage_q;
	// outer indices a,b,c,d and inner e,f; stage 3 moves d inside
	logic [2:0] a_q, b_q, c_q, d_q, e_q, f_q;
	logic [2:0] lb, ld, le, lf;
	logic inner_last, outer_last;
	logic [7:0] idx;
	logic [2:0] dcnt_q;

	function automatic logic [tloa_pkg::ENV_AW-1:0] ENV_AWfn(input int v);
		return v[tloa_pkg::ENV_AW-1:0];
	endfunction
	function automatic logic [tloa_pkg::VEC_AW-1:0] VEC_AWfn(input int v);
		return v[tloa_pkg::VEC_AW-1:0];
	endfunction
	function automatic logic [tloa_pkg::ST1_AW-1:0] ST1_AWfn(input int v);
		return v[tloa_pkg::ST1_AW-1:0];
	endfunction
	function automatic logic [tloa_pkg::CORE_AW-1:0] CORE_AWfn(input int v);
		return v[tloa_pkg::CORE_AW-1:0];
	endfunction
	function automatic logic [tloa_pkg::ST2_AW-1:0] ST2_AWfn(input int v);
		return v[tloa_pkg::ST2_AW-1:0];
	endfunction

	// stage 3: outer order a,c,b; inner pair d (R over nL), e (S over nS)
	wire in3 = (stage_q == 2'd3);
	wire [2:0] s3_R = d_q;
	wire [2:0] s3_S = e_q;
	wire s3_inner_last = (e_q == sz.nS - 3'd1) && (d_q == sz.nL - 3'd1);

	always_comb begin
		lb = sz.ns; ld = sz.nL; le = sz.nl; lf = 3'd1;
		case (stage_q)
			2'd1: begin lb = sz.ns; ld = sz.nL; le = sz.nl; lf = 3'd1; end
			2'd2: begin lb = sz.nL; ld = sz.nS; le = sz.ns; lf = sz.nm; end
			2'd3: begin lb = sz.nL; ld = sz.nL; le = sz.nS; lf = 3'd1; end
			default: ;
		endcase
	end

	assign inner_last = in3 ? s3_inner_last :
		((e_q == le - 3'd1) && (f_q == lf - 3'd1));
	assign outer_last = in3 ?
		((a_q == sz.nl - 3'd1) && (c_q == sz.nm - 3'd1) && (b_q == sz.nL - 3'd1)) :
		((a_q == sz.nl - 3'd1) && (b_q == lb - 3'd1) &&
		(c_q == sz.nm - 3'd1) && (d_q == ld - 3'd1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			stage_q <= 2'd1;
			{a_q, b_q, c_q, d_q, e_q, f_q} <= '0;
			dcnt_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (go) begin
						state_q <= S_RUN;
						stage_q <= 2'd1;
						{a_q, b_q, c_q, d_q, e_q, f_q} <= '0;
					end
				end
				S_RUN: begin
					if (inner_last) begin
						e_q <= '0; f_q <= '0;
						if (stage_q == 2'd3) begin
							// inner pair restarts, outer a,c,b advances
							d_q <= '0;
							if (outer_last) begin
								state_q <= S_DRAIN; dcnt_q <= '0;
							end else if (b_q == lb - 3'd1) begin
								b_q <= '0;
								if (c_q == sz.nm - 3'd1) begin c_q <= '0; a_q <= a_q + 3'd1; end
								else c_q <= c_q + 3'd1;
							end else b_q <= b_q + 3'd1;
						end else if (outer_last) begin
							state_q <= S_DRAIN; dcnt_q <= '0;
						end else if (d_q == ld - 3'd1) begin
							d_q <= '0;
							if (c_q == sz.nm - 3'd1) begin
								c_q <= '0;
								if (b_q == lb - 3'd1) begin b_q <= '0; a_q <= a_q + 3'd1; end
								else b_q <= b_q + 3'd1;
							end else c_q <= c_q + 3'd1;
						end else d_q <= d_q + 3'd1;
					end else if (stage_q == 2'd3) begin
						if (e_q == le - 3'd1) begin e_q <= '0; d_q <= d_q + 3'd1; end
						else e_q <= e_q + 3'd1;
					end else if (f_q == lf - 3'd1) begin
						f_q <= '0; e_q <= e_q + 3'd1;
					end else f_q <= f_q + 3'd1;
				end
				S_DRAIN: begin
					// let the write-back of the last sum land before next stage reads
					dcnt_q <= dcnt_q + 3'd1;
					if (dcnt_q == 3'd4) begin
						{a_q, b_q, c_q, d_q, e_q, f_q} <= '0;
						if (stage_q == 2'd3) state_q <= S_IDLE;
						else begin
							stage_q <= stage_q + 2'd1;
							state_q <= S_RUN;
						end
					end
				end
				S_REG: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);

	always_comb begin
		ctl.mac   = (state_q == S_RUN);
		ctl.stage = stage_q;
		if (in3) begin
			ctl.clr = (d_q == 3'd0) && (e_q == 3'd0);
			ctl.fin = s3_inner_last;
		end else begin
			ctl.clr = (e_q == 3'd0) && (f_q == 3'd0);
			ctl.fin = inner_last;
		end
	end

	// addresses, all flat row-major at the current sizes
	always_comb begin
		left_ra  = ENV_AWfn((a_q * sz.ns + b_q) * sz.nl + e_q);
		vec_ra   = VEC_AWfn((e_q * sz.nm + c_q) * sz.nL + d_q);
		st1_ra   = ST1_AWfn(((a_q * sz.ns + e_q) * sz.nm + f_q) * sz.nL + b_q);
		core_ra  = CORE_AWfn(((e_q * sz.nm + c_q) * sz.nm + f_q) * sz.nS + d_q);
		st2_ra   = ST2_AWfn(((a_q * sz.nL + s3_R) * sz.nm + c_q) * sz.nS + s3_S);
		right_ra = ENV_AWfn((b_q * sz.nS + s3_S) * sz.nL + s3_R);
		idx      = 8'((int'(a_q) * sz.nm + c_q) * sz.nL + b_q);
		if (in3) vec_ra = VEC_AWfn(32'(idx));
		out_idx  = idx;
		out_last = (a_q == sz.nl - 3'd1) && (c_q == sz.nm - 3'd1) &&
			(b_q == sz.nL - 3'd1);
	end
endmodule

[src/tloa_mac.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tloa_mac
// product pipeline and wide accumulator with rounding and saturation
// ----------------------------------------------------------------------------
module tloa_mac (
	input  logic                      clk,
	input  logic                      arst_n,
	input  tloa_pkg::mac_ctl_t        ctl_s1,
	input  logic signed [31:0]        x_s1,
	input  logic signed [31:0]        y_s1,
	input  logic signed [31:0]        rx_s1,
	input  logic signed [31:0]        ry_s1,
	output logic                      done,
	output logic [1:0]                done_stage,
	output logic signed [31:0]        done_value
);
	tloa_pkg::mac_ctl_t ctl_s2, ctl_s3;
	logic signed [63:0] p_s2, rp_s2;
	logic signed [tloa_pkg::ACC_W-1:0] acc_q, sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else begin
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		p_s2  <= x_s1 * y_s1;
		rp_s2 <= rx_s1 * ry_s1;
	end

	// regularization product joins the first term of each stage-3 output sum
	always_comb begin
		sum = (ctl_s2.clr ? '0 : acc_q) + tloa_pkg::ACC_W'(p_s2);
		if (ctl_s2.clr && ctl_s2.stage == 2'd3) sum = sum + tloa_pkg::ACC_W'(rp_s2);
	end

	always_ff @(posedge clk) begin
		if (ctl_s2.mac) acc_q <= sum;
	end

	assign done       = ctl_s3.mac && ctl_s3.fin;
	assign done_stage = ctl_s3.stage;
	assign done_value = tloa_pkg::finish(acc_q);
endmodule

[src/tloa_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tloa_checker
// port-level checks for the local operator apply block
// ----------------------------------------------------------------------------
module tloa_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic [2:0] action,
	input logic       valid,
	input logic       last,
	input logic       pready
);
	a_valid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> busy) else $error("result outside compute");
	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && action != tloa_pkg::ACT_COMPUTE |=> !busy)
		else $error("write set busy");
	a_compute_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && action == tloa_pkg::ACT_COMPUTE |=> busy)
		else $error("compute not taken");
	a_last_valid: assert property (@(posedge clk) disable iff (!arst_n)
		last && valid |=> !valid) else $error("result after last");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		pready) else $error("pready low");
endmodule

bind tt_local_operator_apply_top tloa_checker u_chk (
	.clk, .arst_n, .start, .busy, .action, .valid, .last, .pready
);

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for tt_local_operator_apply_top: loads the four operand
// stores through item writes, runs contractions under a series of size and
// regularization settings, and checks every result strobe against an
// in-bench fixed-point contraction model
// ----------------------------------------------------------------------------
module testbench;

	// one item on the command channel
	typedef struct {
		logic [2:0]  act;
		logic [7:0]  idx;
		logic [31:0] val;
	} cmd_t;

	// one output element
	typedef struct {
		logic [31:0] val;
		logic [5:0]  idx;
		logic        lst;
	} elem_t;

	// 2^47: a q32.32 sum at or past this saturates after rounding
	localparam logic signed [79:0] SAT_EDGE = 80'sh8000_0000_0000;
	localparam int WATCHDOG_LIMIT = 60000;
	localparam int SETTLE_CYCLES  = 40;
	localparam int N_PHASES       = 10;
	localparam int PHASE_ITEMS    = 14;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [2:0]         action;
	logic [7:0]         index;
	logic signed [31:0] value;
	logic               valid;
	logic signed [31:0] result_value;
	logic [5:0]         result_index;
	logic               last;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [4:0]         paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;

	tt_local_operator_apply_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.action       (action),
		.index        (index),
		.value        (value),
		.valid        (valid),
		.result_value (result_value),
		.result_index (result_index),
		.last         (last),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	// pending items, filled by the sequence, drained by the driver
	cmd_t  pending_cmds[$];
	// output elements that the contraction model says are still to come
	elem_t expected_elems[$];

	// model copy of the block's registers and memories
	logic [2:0] size_reg[5];
	logic [31:0] shift_reg;
	int left_mem[tloa_pkg::ENV_DEPTH];
	int core_mem[tloa_pkg::CORE_DEPTH];
	int right_mem[tloa_pkg::ENV_DEPTH];
	int vec_mem[tloa_pkg::VEC_DEPTH];
	int t1_mem[tloa_pkg::ST1_DEPTH];
	int t2_mem[tloa_pkg::ST2_DEPTH];

	// which store entries the sequence has written so far
	bit left_done[tloa_pkg::ENV_DEPTH];
	bit core_done[tloa_pkg::CORE_DEPTH];
	bit right_done[tloa_pkg::ENV_DEPTH];
	bit vec_done[tloa_pkg::VEC_DEPTH];

	int  idle_pct;
	bit  took_item;
	int  stall_count;
	int  mismatches;
	int  n_items;
	int  n_computes;
	int  n_elems;

	// ------------------------------------------------------------------
	// clock and reset
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// ------------------------------------------------------------------
	// contraction model
	// ------------------------------------------------------------------

	// a size register of 0 acts as 1, above the maximum as the maximum
	function automatic int eff_size(input logic [2:0] v, input int mx);
		if (v == 3'd0)
			return 1;
		if (int'(v) > mx)
			return mx;
		return int'(v);
	endfunction

	function automatic logic signed [79:0] wide_mul(input int a, input int b);
		logic signed [79:0] p;
		p = longint'(a) * longint'(b);
		return p;
	endfunction

	// q32.32 sum to q16.16, ties toward +inf, saturate
	function automatic int round_sat(input logic signed [79:0] sum);
		logic signed [79:0] r;
		r = sum + 80'sd32768;
		if (r >= SAT_EDGE)
			return 32'h7fffffff;
		if (r < -SAT_EDGE)
			return 32'h80000000;
		return int'(r[47:16]);
	endfunction

	task automatic contract_operator();
		int nl, ns, nm, nS, nL;
		int a, b, c, d, e, f, flat, k, total;
		logic signed [79:0] sum;
		elem_t el;
		nl = eff_size(size_reg[tloa_pkg::REG_LEFT_RANK], tloa_pkg::MAX_BOND_RANK);
		ns = eff_size(size_reg[tloa_pkg::REG_LEFT_OP], tloa_pkg::MAX_OP_RANK);
		nm = eff_size(size_reg[tloa_pkg::REG_MODE], tloa_pkg::MAX_MODE);
		nS = eff_size(size_reg[tloa_pkg::REG_RIGHT_OP], tloa_pkg::MAX_OP_RANK);
		nL = eff_size(size_reg[tloa_pkg::REG_RIGHT_RANK], tloa_pkg::MAX_BOND_RANK);
		// left environment against the vector
		for (a = 0; a < nl; a++)
			for (b = 0; b < ns; b++)
				for (c = 0; c < nm; c++)
					for (d = 0; d < nL; d++) begin
						sum = '0;
						for (e = 0; e < nl; e++)
							sum += wide_mul(left_mem[(a*ns+b)*nl+e], vec_mem[(e*nm+c)*nL+d]);
						t1_mem[((a*ns+b)*nm+c)*nL+d] = round_sat(sum);
					end
		// through the operator core
		for (a = 0; a < nl; a++)
			for (b = 0; b < nL; b++)
				for (c = 0; c < nm; c++)
					for (d = 0; d < nS; d++) begin
						sum = '0;
						for (e = 0; e < ns; e++)
							for (f = 0; f < nm; f++)
								sum += wide_mul(t1_mem[((a*ns+e)*nm+f)*nL+b],
									core_mem[((e*nm+c)*nm+f)*nS+d]);
						t2_mem[((a*nL+b)*nm+c)*nS+d] = round_sat(sum);
					end
		// right environment plus the shift term, emitted row-major
		total = nl * nm * nL;
		k = 0;
		for (a = 0; a < nl; a++)
			for (c = 0; c < nm; c++)
				for (b = 0; b < nL; b++) begin
					flat = (a*nm+c)*nL+b;
					sum = '0;
					for (d = 0; d < nL; d++)
						for (e = 0; e < nS; e++)
							sum += wide_mul(t2_mem[((a*nL+d)*nm+c)*nS+e],
								right_mem[(b*nS+e)*nL+d]);
					sum += wide_mul(int'(shift_reg), vec_mem[flat]);
					el.val = round_sat(sum);
					el.idx = flat[5:0];
					el.lst = (k + 1 == total);
					expected_elems.push_back(el);
					k++;
				end
	endtask

	task automatic apply_item(input cmd_t c);
		case (c.act)
			tloa_pkg::ACT_LEFT:
				if (c.idx < tloa_pkg::ENV_DEPTH) left_mem[c.idx] = int'(c.val);
			tloa_pkg::ACT_CORE:
				if (c.idx < tloa_pkg::CORE_DEPTH) core_mem[c.idx] = int'(c.val);
			tloa_pkg::ACT_RIGHT:
				if (c.idx < tloa_pkg::ENV_DEPTH) right_mem[c.idx] = int'(c.val);
			tloa_pkg::ACT_VECTOR:
				if (c.idx < tloa_pkg::VEC_DEPTH) vec_mem[c.idx] = int'(c.val);
			tloa_pkg::ACT_COMPUTE: begin
				contract_operator();
				n_computes++;
			end
			default: ;
		endcase
	endtask

	// ------------------------------------------------------------------
	// driver: new item at the falling edge once the last one was taken
	// ------------------------------------------------------------------
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start  <= 1'b0;
			action <= '0;
			index  <= '0;
			value  <= '0;
		end else if (!start || took_item) begin
			if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
				cmd_t c;
				c = pending_cmds.pop_front();
				start  <= 1'b1;
				action <= c.act;
				index  <= c.idx;
				value  <= c.val;
			end else begin
				start  <= 1'b0;
				// scribble on the idle bus so nothing depends on it
				action <= 3'($urandom);
				index  <= 8'($urandom);
				value  <= $urandom;
			end
		end
	end

	// ------------------------------------------------------------------
	// monitor: acceptance, result checking and the watchdog
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		took_item = 1'b0;
		if (arst_n) begin
			if (start && !busy) begin
				cmd_t c;
				c.act = action;
				c.idx = index;
				c.val = value;
				apply_item(c);
				took_item = 1'b1;
				n_items++;
			end
			if (valid) begin
				n_elems++;
				if (expected_elems.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: value %h index %0d last %b",
							result_value, result_index, last);
				end else begin
					elem_t el;
					el = expected_elems.pop_front();
					if (result_value !== el.val || result_index !== el.idx
						|| last !== el.lst) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp value %h index %0d last %b, got %h %0d %b",
								el.val, el.idx, el.lst, result_value, result_index, last);
					end
				end
			end
			// only handshakes count as progress
			if (took_item || valid)
				stall_count = 0;
			else
				stall_count++;
			if (stall_count >= WATCHDOG_LIMIT) begin
				$display("watchdog expired with %0d results outstanding", expected_elems.size());
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// sequence helpers
	// ------------------------------------------------------------------
	function automatic logic [31:0] rand_q16();
		// mostly values within +-2.0, sometimes anything
		if ($urandom_range(0, 3) == 0)
			return $urandom;
		return 32'($urandom_range(0, 262143) - 131072);
	endfunction

	task automatic push_cmd(input logic [2:0] act, input int idx, input logic [31:0] val);
		cmd_t c;
		c.act = act;
		c.idx = idx[7:0];
		c.val = val;
		pending_cmds.push_back(c);
		case (act)
			tloa_pkg::ACT_LEFT:   if (idx < tloa_pkg::ENV_DEPTH) left_done[idx] = 1'b1;
			tloa_pkg::ACT_CORE:   if (idx < tloa_pkg::CORE_DEPTH) core_done[idx] = 1'b1;
			tloa_pkg::ACT_RIGHT:  if (idx < tloa_pkg::ENV_DEPTH) right_done[idx] = 1'b1;
			tloa_pkg::ACT_VECTOR: if (idx < tloa_pkg::VEC_DEPTH) vec_done[idx] = 1'b1;
			default: ;
		endcase
	endtask

	// load every entry the next contraction reads that was never written,
	// then queue the compute
	task automatic push_compute();
		int nl, ns, nm, nS, nL, i;
		nl = eff_size(size_reg[tloa_pkg::REG_LEFT_RANK], tloa_pkg::MAX_BOND_RANK);
		ns = eff_size(size_reg[tloa_pkg::REG_LEFT_OP], tloa_pkg::MAX_OP_RANK);
		nm = eff_size(size_reg[tloa_pkg::REG_MODE], tloa_pkg::MAX_MODE);
		nS = eff_size(size_reg[tloa_pkg::REG_RIGHT_OP], tloa_pkg::MAX_OP_RANK);
		nL = eff_size(size_reg[tloa_pkg::REG_RIGHT_RANK], tloa_pkg::MAX_BOND_RANK);
		for (i = 0; i < nl*ns*nl; i++)
			if (!left_done[i]) push_cmd(tloa_pkg::ACT_LEFT, i, rand_q16());
		for (i = 0; i < ns*nm*nm*nS; i++)
			if (!core_done[i]) push_cmd(tloa_pkg::ACT_CORE, i, rand_q16());
		for (i = 0; i < nL*nS*nL; i++)
			if (!right_done[i]) push_cmd(tloa_pkg::ACT_RIGHT, i, rand_q16());
		for (i = 0; i < nl*nm*nL; i++)
			if (!vec_done[i]) push_cmd(tloa_pkg::ACT_VECTOR, i, rand_q16());
		push_cmd(tloa_pkg::ACT_COMPUTE, $urandom_range(0, 255), $urandom);
	endtask

	// everything drained, then a settle wait for a trailing write item
	task automatic wait_idle();
		@(posedge clk);
		while (pending_cmds.size() > 0 || start || busy || expected_elems.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic reg_write(input logic [2:0] which, input logic [31:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {which, 2'b00};
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (which == tloa_pkg::REG_REG)
			shift_reg = data;
		else
			size_reg[which] = data[2:0];
	endtask

	task automatic set_sizes(input int l, input int s, input int m, input int sr, input int lr,
		input logic [31:0] shift);
		reg_write(tloa_pkg::REG_LEFT_RANK, 32'(l));
		reg_write(tloa_pkg::REG_LEFT_OP, 32'(s));
		reg_write(tloa_pkg::REG_MODE, 32'(m));
		reg_write(tloa_pkg::REG_RIGHT_OP, 32'(sr));
		reg_write(tloa_pkg::REG_RIGHT_RANK, 32'(lr));
		reg_write(tloa_pkg::REG_REG, shift);
	endtask

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin
		int p, i, r;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		idle_pct    = 17;
		took_item   = 1'b0;
		stall_count = 0;
		mismatches  = 0;
		n_items     = 0;
		n_computes  = 0;
		n_elems     = 0;
		for (i = 0; i < 5; i++)
			size_reg[i] = 3'd1;
		shift_reg = '0;
		@(posedge arst_n);

		// directed: reset sizes, saturation both ways, ignored items
		push_cmd(tloa_pkg::ACT_LEFT, 0, 32'h7fffffff);
		push_cmd(tloa_pkg::ACT_CORE, 0, 32'h7fffffff);
		push_cmd(tloa_pkg::ACT_RIGHT, 0, 32'h7fffffff);
		push_cmd(tloa_pkg::ACT_VECTOR, 0, 32'h7fffffff);
		push_compute();
		push_cmd(tloa_pkg::ACT_LEFT, 0, 32'h80000000);
		push_compute();
		push_cmd(3'd5, 255, 32'hffffffff);
		push_cmd(3'd6, 0, 32'h0);
		push_cmd(3'd7, 170, 32'h55555555);
		push_cmd(tloa_pkg::ACT_LEFT, 255, 32'h12345678);
		push_cmd(tloa_pkg::ACT_RIGHT, 64, 32'haaaaaaaa);
		push_cmd(tloa_pkg::ACT_VECTOR, 200, 32'h0);
		push_cmd(tloa_pkg::ACT_CORE, 255, 32'h00010000);
		push_cmd(tloa_pkg::ACT_LEFT, 0, 32'h00010000);
		push_cmd(tloa_pkg::ACT_CORE, 0, 32'hffff0000);
		push_cmd(tloa_pkg::ACT_RIGHT, 0, 32'h00008000);
		push_cmd(tloa_pkg::ACT_VECTOR, 0, 32'h00000001);
		push_compute();

		for (p = 1; p < N_PHASES; p++) begin
			wait_idle();
			// sender idle share: light, then heavy, then none
			idle_pct = (p < 4) ? 17 : (p < 7) ? 74 : 0;
			case (p)
				// full operator ranks, then clamped sizes both ways
				1: set_sizes(2, 4, 2, 4, 2, 32'h00008000);
				2: set_sizes(0, 7, 0, 7, 0, 32'h80000000);
				3: set_sizes(7, 0, 7, 0, 7, 32'h7fffffff);
				default: set_sizes($urandom_range(0, 3), $urandom_range(0, 3),
					$urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 3),
					32'($urandom_range(0, 131072) - 65536));
			endcase
			for (i = 0; i < PHASE_ITEMS; i++) begin
				r = $urandom_range(0, 99);
				if (r < 10)
					push_compute();
				else if (r < 14)
					push_cmd(3'($urandom_range(5, 7)), $urandom_range(0, 255), $urandom);
				else if (r < 18)
					push_cmd(($urandom_range(0, 1) == 0) ? tloa_pkg::ACT_LEFT :
						tloa_pkg::ACT_VECTOR, $urandom_range(64, 255), $urandom);
				else begin
					case ($urandom_range(0, 3))
						0: push_cmd(tloa_pkg::ACT_LEFT,
							$urandom_range(0, tloa_pkg::ENV_DEPTH - 1), rand_q16());
						1: push_cmd(tloa_pkg::ACT_CORE,
							$urandom_range(0, tloa_pkg::CORE_DEPTH - 1), rand_q16());
						2: push_cmd(tloa_pkg::ACT_RIGHT,
							$urandom_range(0, tloa_pkg::ENV_DEPTH - 1), rand_q16());
						default: push_cmd(tloa_pkg::ACT_VECTOR,
							$urandom_range(0, tloa_pkg::VEC_DEPTH - 1), rand_q16());
					endcase
				end
			end
			push_compute();
		end

		wait_idle();
		$display("ran %0d items including %0d contractions over %0d size settings",
			n_items, n_computes, N_PHASES);
		$display("checked %0d output elements, %0d mismatches", n_elems, mismatches);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
